@@ rtl/bbp_pkg.sv @@
// Shared types and constants for the block buffer pool.
package bbp_pkg;

  localparam int SLOTS_DEF        = 64;
  localparam int FILE_ID_BITS_DEF = 8;
  localparam int OFFSET_BITS_DEF  = 16;
  localparam int STAMP_BITS       = 32;

  localparam int REQ_W   = 2;
  localparam int FID_W   = 8;
  localparam int OFF_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET_TOUCH = 2'd0,
    REQ_GET_KEEP  = 2'd1,
    REQ_MARK      = 2'd2,
    REQ_INVAL     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic is_mark;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/bbp_ctrl.sv @@
// Request sequencer for the block buffer pool.
module bbp_ctrl
  import bbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.is_mark) begin
          state_next = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (status.rd_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bbp_dp.sv @@
// Slot storage, tag and LRU scan, and result register for the buffer pool.
module bbp_dp
  import bbp_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int FILE_ID_BITS = FILE_ID_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [FID_W-1:0]    file_id,
  input  logic [OFF_W-1:0]    block_offset,
  input  logic [SLOT_W-1:0]   slot_in,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  input  cmd_t                cmd,
  output status_t             status
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FB = FILE_ID_BITS;
  localparam int OB = OFFSET_BITS;
  localparam logic [31:0] SLOTS_W = 32'(SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  // request registers
  req_t                  req_q;
  logic [FB-1:0]         fid_q;
  logic [OB-1:0]         off_q;
  logic [SLOT_W-1:0]     sin_q;
  logic [STAMP_BITS-1:0] access_counter;

  // storage
  logic [SLOTS-1:0]      valid_bits;
  logic [SLOTS-1:0]      dirty_bits;
  logic [FB+OB-1:0]      tag_mem [SLOTS];
  logic [STAMP_BITS-1:0] stamp_mem [SLOTS];

  // scan
  logic [SW-1:0]         rd_cnt;
  logic                  ev_valid;
  logic [SW-1:0]         ev_idx;
  logic [FB+OB-1:0]      tag_rd;
  logic [STAMP_BITS-1:0] stamp_rd;

  logic                  hit_f;
  logic [SW-1:0]         hit_idx;
  logic                  inv_f;
  logic [SW-1:0]         inv_idx;
  logic                  all_f;
  logic [SW-1:0]         all_idx;
  logic [STAMP_BITS-1:0] all_stamp;
  logic [FB+OB-1:0]      all_tag;
  logic                  all_dirty;
  logic                  nf_f;
  logic [SW-1:0]         nf_idx;
  logic [STAMP_BITS-1:0] nf_stamp;
  logic [FB+OB-1:0]      nf_tag;
  logic                  nf_dirty;

  // result register
  logic [SLOT_W-1:0]     r_slot;
  logic                  r_hit;
  logic                  r_fill;
  logic                  r_wb;
  logic [FID_W-1:0]      r_wf;
  logic [OFF_W-1:0]      r_wo;

  // evaluation of the slot read last cycle
  logic                  ev_vbit;
  logic                  ev_dbit;
  logic [FB-1:0]         ev_file;
  logic [OB-1:0]         ev_off;
  logic                  ev_fmatch;
  logic                  ev_hit;

  // commit decisions
  logic                  is_get;
  logic                  use_nf;
  logic [SW-1:0]         vic_idx;
  logic [FB+OB-1:0]      vic_tag;
  logic                  vic_dirty;
  logic                  mark_ok;
  logic [SW-1:0]         mark_idx;
  logic                  tag_we;
  logic                  stamp_we;
  logic [SW-1:0]         wr_idx;

  assign ev_vbit   = valid_bits[ev_idx];
  assign ev_dbit   = dirty_bits[ev_idx];
  assign ev_file   = tag_rd[FB+OB-1:OB];
  assign ev_off    = tag_rd[OB-1:0];
  assign ev_fmatch = (ev_file == fid_q);
  assign ev_hit    = ev_vbit && ev_fmatch && (ev_off == off_q);

  assign is_get    = (req_q == REQ_GET_TOUCH) || (req_q == REQ_GET_KEEP);
  assign use_nf    = (req_q == REQ_GET_KEEP) && nf_f;
  assign vic_idx   = inv_f ? inv_idx : (use_nf ? nf_idx : all_idx);
  assign vic_tag   = use_nf ? nf_tag : all_tag;
  assign vic_dirty = use_nf ? nf_dirty : all_dirty;
  assign mark_ok   = (32'(sin_q) < SLOTS_W);
  assign mark_idx  = SW'(sin_q);

  always_comb begin
    tag_we   = 1'b0;
    stamp_we = 1'b0;
    wr_idx   = vic_idx;
    if (cmd.commit) begin
      case (req_q)
        REQ_GET_TOUCH, REQ_GET_KEEP: begin
          if (hit_f) begin
            wr_idx   = hit_idx;
            stamp_we = (req_q == REQ_GET_TOUCH);
          end else begin
            tag_we   = 1'b1;
            stamp_we = 1'b1;
          end
        end
        REQ_MARK: begin
          wr_idx   = mark_idx;
          stamp_we = mark_ok;
        end
        default: begin
          stamp_we = 1'b0;
        end
      endcase
    end
  end

  assign status.rd_last  = (rd_cnt == LAST_IDX);
  assign status.is_mark  = (req_q == REQ_MARK);
  assign status.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req_t'(req_type);
      fid_q <= FB'(file_id);
      off_q <= OB'(block_offset);
      sin_q <= slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      tag_rd   <= tag_mem[rd_cnt];
      stamp_rd <= stamp_mem[rd_cnt];
    end
    if (tag_we) begin
      tag_mem[wr_idx] <= {fid_q, off_q};
    end
    if (stamp_we) begin
      stamp_mem[wr_idx] <= access_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt   <= '0;
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.scan;
      if (cmd.latch) begin
        rd_cnt <= '0;
      end else if (cmd.scan) begin
        rd_cnt <= rd_cnt + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      ev_idx <= rd_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hit_f <= 1'b0;
      inv_f <= 1'b0;
      all_f <= 1'b0;
      nf_f  <= 1'b0;
    end else if (ev_valid) begin
      if (!hit_f && ev_hit) begin
        hit_f   <= 1'b1;
        hit_idx <= ev_idx;
      end
      if (!inv_f && !ev_vbit) begin
        inv_f   <= 1'b1;
        inv_idx <= ev_idx;
      end
      if (!all_f || (stamp_rd < all_stamp)) begin
        all_f     <= 1'b1;
        all_idx   <= ev_idx;
        all_stamp <= stamp_rd;
        all_tag   <= tag_rd;
        all_dirty <= ev_dbit;
      end
      if (!ev_fmatch && (!nf_f || (stamp_rd < nf_stamp))) begin
        nf_f     <= 1'b1;
        nf_idx   <= ev_idx;
        nf_stamp <= stamp_rd;
        nf_tag   <= tag_rd;
        nf_dirty <= ev_dbit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits     <= '0;
      dirty_bits     <= '0;
      access_counter <= '0;
    end else begin
      if (ev_valid && (req_q == REQ_INVAL) && ev_vbit && ev_fmatch) begin
        valid_bits[ev_idx] <= 1'b0;
        dirty_bits[ev_idx] <= 1'b0;
      end
      if (tag_we) begin
        valid_bits[wr_idx] <= 1'b1;
        dirty_bits[wr_idx] <= 1'b0;
      end
      if (cmd.commit && (req_q == REQ_MARK) && mark_ok) begin
        dirty_bits[mark_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        access_counter <= access_counter + STAMP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      r_slot <= '0;
      r_hit  <= 1'b0;
      r_fill <= 1'b0;
      r_wb   <= 1'b0;
      r_wf   <= '0;
      r_wo   <= '0;
      if (is_get) begin
        if (hit_f) begin
          r_slot <= SLOT_W'(hit_idx);
          r_hit  <= 1'b1;
        end else begin
          r_slot <= SLOT_W'(vic_idx);
          r_fill <= 1'b1;
          if (!inv_f && vic_dirty) begin
            r_wb <= 1'b1;
            r_wf <= FID_W'(vic_tag[FB+OB-1:OB]);
            r_wo <= OFF_W'(vic_tag[OB-1:0]);
          end
        end
      end else if (req_q == REQ_MARK) begin
        r_slot <= sin_q;
      end
    end
  end

  assign m_tdata = {7'd0, r_wo, r_wf, r_wb, r_fill, r_hit, r_slot};

endmodule

@@ rtl/block_buffer_pool_lru.sv @@
// Fully associative block buffer pool with LRU replacement: top level.
//
// Each request is accepted on the slave stream and answered by exactly one
// result on the master stream. A get, or an invalidate, walks every slot
// once through the single read port of the tag and stamp memories, one slot
// per cycle, then passes the drain state; a mark-written request skips the
// walk and goes from the scan state straight to the done state. One
// request is in flight at a time; a finished result waits in an output
// register and does not hold off the next request's scan. Stamps come from
// a 32-bit request counter that wraps, so LRU order across a wrap is lost.
module block_buffer_pool_lru
  import bbp_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int FILE_ID_BITS = FILE_ID_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // file_id[7:0], block_offset[23:8], slot_in[29:24]
  input  logic [REQ_W-1:0]    s_tuser,  // req_type[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // slot[5:0], hit[6], fill_needed[7], writeback[8],
                                        // wb_file_id[16:9], wb_block_offset[32:17]
);

  cmd_t    cmd;
  status_t status;

  bbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bbp_dp #(
    .SLOTS        (SLOTS),
    .FILE_ID_BITS (FILE_ID_BITS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_type     (s_tuser),
    .file_id      (s_tdata[7:0]),
    .block_offset (s_tdata[23:8]),
    .slot_in      (s_tdata[29:24]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cmd          (cmd),
    .status       (status)
  );

  a_commit_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("result committed over a pending result");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !s_tready)
    else $error("request accepted during slot scan");

endmodule
